/* src/ndvi_pkg.sv */
// Shared constants and types for the NDVI reflectance pixel pipeline.
// Used by the result interface, the top level and the testbench.
`default_nettype none
package ndvi_pkg;
	localparam int GAIN_W     = 24;
	localparam int REFL_W     = 24;
	localparam int NDVI_W     = 16;
	localparam int NDVI_FRAC  = 14;
	localparam int NDVI_Q_W   = NDVI_FRAC + 1;
	localparam int CODE_W     = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [REFL_W-1:0] REFL_MAX = '1;
	localparam logic [NDVI_W-1:0] NDVI_ONE = NDVI_W'(1) << NDVI_FRAC;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_RED_GAIN = 1'b0,
		REG_NIR_GAIN = 1'b1
	} reg_idx_t;
endpackage
`default_nettype wire

/* src/ndvi_if.sv */
// Valid/ready channels for the pixel input word and the result word.
// Depends on ndvi_pkg for the fixed output widths.
`default_nettype none
interface ndvi_in_if #(parameter int SAMPLE_BITS = 12);
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_BITS-1:0]  red_raw;
	logic [SAMPLE_BITS-1:0]  red_dark;
	logic [SAMPLE_BITS-1:0]  red_span;
	logic signed [SAMPLE_BITS:0] nir_signal;
	logic [SAMPLE_BITS-1:0]  nir_span;
	modport source (output valid, red_raw, red_dark, red_span, nir_signal, nir_span,
		input ready);
	modport sink (input valid, red_raw, red_dark, red_span, nir_signal, nir_span,
		output ready);
endinterface

interface ndvi_out_if;
	logic                              valid;
	logic                              ready;
	logic [ndvi_pkg::REFL_W-1:0]       red_reflectance;
	logic [ndvi_pkg::REFL_W-1:0]       nir_reflectance;
	logic signed [ndvi_pkg::NDVI_W-1:0] ndvi_value;
	logic [ndvi_pkg::CODE_W-1:0]       ndvi_code;
	modport source (output valid, red_reflectance, nir_reflectance, ndvi_value, ndvi_code,
		input ready);
	modport sink (input valid, red_reflectance, nir_reflectance, ndvi_value, ndvi_code,
		output ready);
endinterface
`default_nettype wire

/* src/ndvi_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num < den << Q_W; carries a side word alongside. No package use.
`default_nettype none
module ndvi_div_pipe #(
	parameter int NUM_W  = 37,
	parameter int DEN_W  = 12,
	parameter int Q_W    = 24,
	parameter int PASS_W = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [PASS_W-1:0] pass_in,
	output      logic              out_valid,
	output      logic [Q_W-1:0]    quo,
	output      logic [PASS_W-1:0] pass_out
);
	logic              v_s    [Q_W];
	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    low_s  [Q_W];
	logic [Q_W-1:0]    q_s    [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [PASS_W-1:0] pass_s [Q_W];

	logic [NUM_W-Q_W-1:0] top;
	assign top = num[NUM_W-1:Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic              pv;
		logic [DEN_W-1:0]  prem;
		logic [Q_W-1:0]    plow;
		logic [Q_W-1:0]    pq;
		logic [DEN_W-1:0]  pden;
		logic [PASS_W-1:0] ppass;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              ge;

		// pick up the previous stage, or the input word for the first
		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = DEN_W'(top);
			assign plow  = num[Q_W-1:0];
			assign pq    = '0;
			assign pden  = den;
			assign ppass = pass_in;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign prem  = rem_s[i-1];
			assign plow  = low_s[i-1];
			assign pq    = q_s[i-1];
			assign pden  = den_s[i-1];
			assign ppass = pass_s[i-1];
		end

		// shift in the next numerator bit and try a subtract
		always_comb begin
			trial = {prem, plow[Q_W-1]};
			diff  = trial - {1'b0, pden};
			ge    = trial >= {1'b0, pden};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[i]  <= plow << 1;
				q_s[i]    <= {pq[Q_W-2:0], ge};
				den_s[i]  <= pden;
				pass_s[i] <= ppass;
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = q_s[Q_W-1];
	assign pass_out  = pass_s[Q_W-1];
endmodule
`default_nettype wire

/* src/ndvi_reflectance_pixel.sv */
// NDVI reflectance pixel pipeline, top level: APB gain registers, two
// reflectance dividers and the NDVI divider. Depends on ndvi_pkg, ndvi_if, ndvi_div_pipe.
//
// Usage: pixel words enter on samples (valid/ready) and results leave on
// results (valid/ready). Each word carries a red sample with dark and span and
// an aligned NIR signal with span; the result word carries both reflectances
// (Q8.16), NDVI (Q2.14) and an 8-bit display code.
// Throughput: one word per clock while the output is not stalled. From acceptance to
// result valid a word passes one multiply stage, 24 reflectance divider stages, one
// reflectance stage, 15 NDVI divider stages and the output register. Depth is set by the
// one-bit-per-stage dividers.
// Gains are written over APB (red_gain at 0x0, nir_gain at 0x4) only while idle; the
// user must keep to this, as the block does not enforce it. Reset clears all valid
// bits and sets both gains to 1.0. When results.ready is low with a result waiting,
// the whole pipe holds and samples.ready drops; nothing is lost or repeated.
`default_nettype none
module ndvi_reflectance_pixel #(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ndvi_in_if.sink   samples,
	ndvi_out_if.source results,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [ndvi_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ndvi_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [ndvi_pkg::APB_DATA_W-1:0] prdata,
	output      logic pready
);
	localparam int SB      = SAMPLE_BITS;
	localparam int GW      = ndvi_pkg::GAIN_W;
	localparam int RW      = ndvi_pkg::REFL_W;
	localparam int PROD_W  = SB + GW;
	localparam int RNUM_W  = PROD_W + 1;
	localparam int SUM_W   = RW + 1;
	localparam int FR      = ndvi_pkg::NDVI_FRAC;
	localparam int QW      = ndvi_pkg::NDVI_Q_W;
	localparam int DNUM_W  = RW + FR + 1;
	localparam int NW      = ndvi_pkg::NDVI_W;
	localparam int CW      = ndvi_pkg::CODE_W;
	localparam int T_W     = NW + CW;
	localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

	logic [GW-1:0] red_gain_q;
	logic [GW-1:0] nir_gain_q;
	logic          adv;
	ndvi_pkg::reg_idx_t reg_idx;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = ndvi_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_gain_q <= GAIN_ONE;
			nir_gain_q <= GAIN_ONE;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				ndvi_pkg::REG_RED_GAIN: red_gain_q <= pwdata[GW-1:0];
				ndvi_pkg::REG_NIR_GAIN: nir_gain_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ndvi_pkg::REG_RED_GAIN: prdata = ndvi_pkg::APB_DATA_W'(red_gain_q);
			ndvi_pkg::REG_NIR_GAIN: prdata = ndvi_pkg::APB_DATA_W'(nir_gain_q);
			default:                prdata = '0;
		endcase
	end

	// advance the whole pipe unless a result is held
	logic v_s3;
	assign adv           = !v_s3 || results.ready;
	assign samples.ready = adv;

	// stage 1: signal, zero flags and gain products
	logic [SB:0]   rdiff;
	logic          rzero;
	logic          nzero;
	logic          v_s1;
	logic [PROD_W-1:0] rprod_s1, nprod_s1;
	logic [SB-1:0] rspan_s1, nspan_s1;
	logic          rzero_s1, nzero_s1;

	always_comb begin
		rdiff = {1'b0, samples.red_raw} - {1'b0, samples.red_dark};
		rzero = rdiff[SB] || (rdiff == '0) || (samples.red_span == '0);
		nzero = samples.nir_signal[SB] || (samples.nir_signal == '0)
			|| (samples.nir_span == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rprod_s1 <= PROD_W'(rdiff[SB-1:0]) * PROD_W'(red_gain_q);
			nprod_s1 <= PROD_W'(samples.nir_signal[SB-1:0]) * PROD_W'(nir_gain_q);
			rspan_s1 <= samples.red_span;
			nspan_s1 <= samples.nir_span;
			rzero_s1 <= rzero;
			nzero_s1 <= nzero;
		end
	end

	// rounding offset and saturation check ahead of the dividers
	logic [RNUM_W-1:0] rnum, nnum;
	logic              rovf, novf;

	always_comb begin
		rnum = RNUM_W'(rprod_s1) + RNUM_W'(rspan_s1 >> 1);
		nnum = RNUM_W'(nprod_s1) + RNUM_W'(nspan_s1 >> 1);
		rovf = rnum[RNUM_W-1:RW] >= (SB+1)'(rspan_s1);
		novf = nnum[RNUM_W-1:RW] >= (SB+1)'(nspan_s1);
	end

	logic          rdv, ndv;
	logic [RW-1:0] rquo, nquo;
	logic [1:0]    rflag, nflag;

	ndvi_div_pipe #(.NUM_W(RNUM_W), .DEN_W(SB), .Q_W(RW), .PASS_W(2)) u_red_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.num(rnum), .den(rspan_s1), .pass_in({rzero_s1, rovf}),
		.out_valid(rdv), .quo(rquo), .pass_out(rflag)
	);

	ndvi_div_pipe #(.NUM_W(RNUM_W), .DEN_W(SB), .Q_W(RW), .PASS_W(2)) u_nir_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.num(nnum), .den(nspan_s1), .pass_in({nzero_s1, novf}),
		.out_valid(ndv), .quo(nquo), .pass_out(nflag)
	);

	// stage 2: final reflectances
	logic          v_s2;
	logic [RW-1:0] rrefl_s2, nrefl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= rdv && ndv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rrefl_s2 <= rflag[1] ? '0 : (rflag[0] ? ndvi_pkg::REFL_MAX : rquo);
			nrefl_s2 <= nflag[1] ? '0 : (nflag[0] ? ndvi_pkg::REFL_MAX : nquo);
		end
	end

	// NDVI numerator: |n - r| scaled, plus half the sum for rounding
	logic [SUM_W-1:0]  dsum;
	logic [RW-1:0]     dmag;
	logic              dneg;
	logic [DNUM_W-1:0] dnum;

	always_comb begin
		dsum = SUM_W'(nrefl_s2) + SUM_W'(rrefl_s2);
		dneg = nrefl_s2 < rrefl_s2;
		dmag = dneg ? (rrefl_s2 - nrefl_s2) : (nrefl_s2 - rrefl_s2);
		dnum = {1'b0, dmag, FR'(0)} + DNUM_W'(dsum >> 1);
	end

	logic                  ddv;
	logic [QW-1:0]         dquo;
	logic [2*RW+1:0]       dpass;

	ndvi_div_pipe #(.NUM_W(DNUM_W), .DEN_W(SUM_W), .Q_W(QW), .PASS_W(2*RW+2)) u_ndvi_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s2),
		.num(dnum), .den(dsum),
		.pass_in({dsum == '0, dneg, rrefl_s2, nrefl_s2}),
		.out_valid(ddv), .quo(dquo), .pass_out(dpass)
	);

	// signed NDVI and display code
	logic signed [NW-1:0] qv;
	logic [NW-1:0]        biased;
	logic [T_W-1:0]       tcode;
	logic [T_W-16:0]      craw;

	always_comb begin
		if (dpass[2*RW+1]) begin
			qv = '0;
		end else if (dpass[2*RW]) begin
			qv = -$signed(NW'(dquo));
		end else begin
			qv = $signed(NW'(dquo));
		end
		biased = NW'(qv) + ndvi_pkg::NDVI_ONE;
		tcode  = (T_W'(biased) << CW) - T_W'(biased) + T_W'(ndvi_pkg::NDVI_ONE);
		craw   = tcode[T_W-1:15];
	end

	// stage 3: output register
	logic [RW-1:0]        rrefl_s3, nrefl_s3;
	logic signed [NW-1:0] ndvi_s3;
	logic [CW-1:0]        code_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= ddv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rrefl_s3 <= dpass[2*RW-1:RW];
			nrefl_s3 <= dpass[RW-1:0];
			ndvi_s3  <= qv;
			code_s3  <= (craw > (T_W-15)'(255)) ? '1 : craw[CW-1:0];
		end
	end

	assign results.valid           = v_s3;
	assign results.red_reflectance = rrefl_s3;
	assign results.nir_reflectance = nrefl_s3;
	assign results.ndvi_value      = ndvi_s3;
	assign results.ndvi_code       = code_s3;
endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for ndvi_reflectance_pixel: directed and random pixel words under
// several idle/stall phases. Depends on ndvi_pkg, ndvi_if and the top level RTL.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = 12;
	localparam int LATENCY = 42;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [SB-1:0] red_raw;
		logic [SB-1:0] red_dark;
		logic [SB-1:0] red_span;
		logic signed [SB:0] nir_signal;
		logic [SB-1:0] nir_span;
	} pixel_t;

	typedef struct {
		logic [ndvi_pkg::REFL_W-1:0] red_refl;
		logic [ndvi_pkg::REFL_W-1:0] nir_refl;
		logic signed [ndvi_pkg::NDVI_W-1:0] ndvi;
		logic [ndvi_pkg::CODE_W-1:0] code;
	} ndvi_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ndvi_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ndvi_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [ndvi_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	ndvi_in_if #(.SAMPLE_BITS(SB)) samples();
	ndvi_out_if results();

	ndvi_reflectance_pixel #(.SAMPLE_BITS(SB), .GAIN_FRAC_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n), .samples(samples.sink), .results(results.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// gains as the predictor sees them
	logic [ndvi_pkg::GAIN_W-1:0] red_gain_q = 24'h010000;
	logic [ndvi_pkg::GAIN_W-1:0] nir_gain_q = 24'h010000;

	pixel_t pending_px[$];
	ndvi_res_t expected_res[$];
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit recv_hold = 0;
	int mismatches = 0, words_in = 0, words_out = 0, idle_cycles = 0;
	bit timed_out = 0;

	function automatic logic [ndvi_pkg::REFL_W-1:0] reflectance(longint sig, longint span,
			logic [ndvi_pkg::GAIN_W-1:0] gain);
		longint q;
		if (span == 0 || sig <= 0)
			return '0;
		q = (sig * longint'(gain) + span / 2) / span;
		return (q > 64'hFFFFFF) ? ndvi_pkg::REFL_MAX : q[ndvi_pkg::REFL_W-1:0];
	endfunction

	function automatic ndvi_res_t predict_ndvi(pixel_t px);
		ndvi_res_t r;
		longint n, rr, den, mag, qm, q, code;
		rr = reflectance(longint'(px.red_raw) - longint'(px.red_dark), px.red_span, red_gain_q);
		n = reflectance(longint'(px.nir_signal), px.nir_span, nir_gain_q);
		q = 0;
		den = n + rr;
		if (den > 0) begin
			mag = (n >= rr) ? n - rr : rr - n;
			qm = (mag * 16384 + den / 2) / den;
			if (qm > 16384)
				qm = 16384;
			q = (n >= rr) ? qm : -qm;
		end
		code = (((q + 16384) * 255) + 16384) >>> 15;
		if (code > 255)
			code = 255;
		r.red_refl = rr[23:0];
		r.nir_refl = n[23:0];
		r.ndvi = q[15:0];
		r.code = code[7:0];
		return r;
	endfunction

	// drive pixel words from the queue; the front entry is the next word to offer
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples.valid && samples.ready) begin
				expected_res.push_back(predict_ndvi(pending_px.pop_front()));
				words_in++;
			end
			if (!samples.valid || samples.ready) begin
				if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					samples.valid <= 1;
					samples.red_raw <= pending_px[0].red_raw;
					samples.red_dark <= pending_px[0].red_dark;
					samples.red_span <= pending_px[0].red_span;
					samples.nir_signal <= pending_px[0].nir_signal;
					samples.nir_span <= pending_px[0].nir_span;
				end else begin
					samples.valid <= 0;
				end
			end
		end
	end

	// drive ready and check result words
	always @(posedge clk) begin
		ndvi_res_t e;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				words_out++;
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: %h %h %0d %0d",
							results.red_reflectance, results.nir_reflectance,
							results.ndvi_value, results.ndvi_code);
				end else begin
					e = expected_res.pop_front();
					if (results.red_reflectance !== e.red_refl
							|| results.nir_reflectance !== e.nir_refl
							|| results.ndvi_value !== e.ndvi
							|| results.ndvi_code !== e.code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch word %0d: exp %h %h %0d %0d got %h %h %0d %0d",
								words_out, e.red_refl, e.nir_refl, e.ndvi, e.code,
								results.red_reflectance, results.nir_reflectance,
								results.ndvi_value, results.ndvi_code);
					end
				end
			end
			results.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: count cycles with no handshake on either side while words are outstanding
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready)
				|| (pending_px.size() == 0 && expected_res.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("[ndvi_reflectance_pixel] ERROR");
			$finish;
		end
	end

	task automatic apb_write(ndvi_pkg::reg_idx_t idx, logic [ndvi_pkg::GAIN_W-1:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ndvi_pkg::APB_ADDR_W'(idx) << 2; pwdata <= {8'(0), val};
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == ndvi_pkg::REG_RED_GAIN)
			red_gain_q = val;
		else
			nir_gain_q = val;
	endtask

	task automatic add_px(int raw, int dark, int rspan, int nsig, int nspan);
		pixel_t p;
		p.red_raw = SB'(raw); p.red_dark = SB'(dark); p.red_span = SB'(rspan);
		p.nir_signal = (SB+1)'(nsig); p.nir_span = SB'(nspan);
		pending_px.push_back(p);
	endtask

	// wait until every queued word is out, then let the pipe drain
	task automatic drain();
		while (pending_px.size() != 0 || expected_res.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic int rand_sample();
		case ($urandom_range(5))
			0: return 0;
			1: return 4095;
			2: return $urandom_range(15);
			default: return $urandom_range(4095);
		endcase
	endfunction

	task automatic add_random(int count);
		int nsig;
		repeat (count) begin
			nsig = ($urandom_range(3) == 0) ? $urandom_range(8191) - 4096
				: $urandom_range(4095) - ($urandom_range(1) ? 4095 : 0);
			if (nsig < -4096) nsig = -4096;
			add_px(rand_sample(), ($urandom_range(2) == 0) ? rand_sample()
				: $urandom_range(300), ($urandom_range(9) == 0) ? 0 : rand_sample(),
				nsig, ($urandom_range(9) == 0) ? 0 : rand_sample());
		end
	endtask

	function automatic logic [ndvi_pkg::GAIN_W-1:0] rand_gain();
		case ($urandom_range(3))
			0: return 24'hFFFFFF;
			1: return 24'h0;
			default: return ndvi_pkg::GAIN_W'($urandom_range(24'h3FFFF));
		endcase
	endfunction

	initial begin
		samples.valid = 0; samples.red_raw = 0; samples.red_dark = 0;
		samples.red_span = 0; samples.nir_signal = 0; samples.nir_span = 0;
		results.ready = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, zero spans, negatives, saturation, zero sum, ties
		add_px(0, 0, 0, 0, 0);
		add_px(4095, 0, 1, 4095, 1);
		add_px(4095, 0, 4095, 4095, 4095);
		add_px(0, 4095, 4095, -4095, 4095);
		add_px(100, 50, 100, 200, 0);
		add_px(100, 50, 0, 200, 100);
		add_px(1, 0, 2, 1, 2);
		add_px(1, 0, 3, 2, 3);
		add_px(2000, 1000, 4000, -1, 100);
		add_px(10, 20, 30, 1000, 1000);
		add_px(500, 0, 1000, 500, 1000);
		add_px(300, 0, 4095, 3000, 4095);
		add_px(3000, 0, 4095, 300, 4095);
		add_px(4095, 4095, 4095, -4096, 4095);
		add_px(2730, 1365, 2730, 2730, 1365);
		add_px(1, 0, 4095, 0, 4095);
		add_px(0, 0, 4095, 1, 4095);
		drain();
		// phases with different gains and handshake pressure
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					apb_write(ndvi_pkg::REG_RED_GAIN, 24'hFFFFFF);
					apb_write(ndvi_pkg::REG_NIR_GAIN, 24'h0);
				end
				1: begin
					apb_write(ndvi_pkg::REG_RED_GAIN, 24'h0);
					apb_write(ndvi_pkg::REG_NIR_GAIN, 24'hFFFFFF);
				end
				2: begin
					apb_write(ndvi_pkg::REG_RED_GAIN, 24'h008000);
					apb_write(ndvi_pkg::REG_NIR_GAIN, 24'h018000);
				end
				default: begin
					apb_write(ndvi_pkg::REG_RED_GAIN, rand_gain());
					apb_write(ndvi_pkg::REG_NIR_GAIN, rand_gain());
				end
			endcase
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 77 : 25) : 0;
			recv_stall_pct = (ph % 4 == 2) ? 77 : (ph % 4 == 3 ? 25 : 0);
			add_random(ph < 2 ? 120 : 300);
			if (ph == 2) begin
				// long receiver hold while the sender keeps offering words
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			drain();
		end
		send_idle_pct = 0; recv_stall_pct = 0;
		$display("covered %0d pixel words in, %0d results checked, over 7 gain settings",
			words_in, words_out);
		$display("idle/stall phases of 0, 25 and 77 percent plus a long output hold");
		if (mismatches == 0 && expected_res.size() == 0)
			$display("[ndvi_reflectance_pixel] OK");
		else
			$display("[ndvi_reflectance_pixel] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

/* ndvi_reflectance_pixel.f */
src/ndvi_pkg.sv
src/ndvi_if.sv
src/ndvi_div_pipe.sv
src/ndvi_reflectance_pixel.sv
sim/tb.sv
